/* sv/tsr_pkg.sv */
`timescale 1ns / 1ps

package tsr_pkg;

    localparam int COORD_BITS    = 8;
    localparam int COORD_SCALE   = 1 << COORD_BITS;
    localparam int MAX_DIM       = 64;
    localparam int PALETTE_DEPTH = 256;
    localparam int TEXEL_DEPTH   = 4096;

    typedef logic [1:0]  cmd_t;
    typedef logic [11:0] taddr_t;
    typedef logic [3:0][11:0] taddr4_t;
    typedef logic [3:0][16:0] wts_t;
    typedef logic [3:0][15:0] texq_t;

    localparam cmd_t CMD_SAMPLE  = 2'd0;
    localparam cmd_t CMD_TEXEL   = 2'd1;
    localparam cmd_t CMD_PALETTE = 2'd2;

    localparam logic [1:0] MODE_WRAP  = 2'd0;
    localparam logic [1:0] MODE_CLAMP = 2'd1;
    localparam logic [1:0] MODE_ZERO  = 2'd2;

    localparam logic [2:0] REG_ADDR_MODE = 3'd0;
    localparam logic [2:0] REG_BILINEAR  = 3'd1;
    localparam logic [2:0] REG_WIDTH     = 3'd2;
    localparam logic [2:0] REG_HEIGHT    = 3'd3;
    localparam logic [2:0] REG_PAL_EN    = 3'd4;
    localparam logic [2:0] REG_PAL_SIZE  = 3'd5;
    localparam logic [2:0] REG_PAL_OFS   = 3'd6;

    typedef struct packed {
        logic                  reject;
        logic [COORD_BITS-1:0] val;
    } coord_t;

    typedef struct packed {
        cmd_t               cmd;
        logic signed [23:0] u;
        logic signed [23:0] v;
        logic [11:0]        waddr;
        logic [15:0]        wdata;
    } st1_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        reject;
        logic [14:0] pu;
        logic [14:0] pv;
        logic [11:0] waddr;
        logic [15:0] wdata;
    } st2_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        reject;
        taddr4_t     addr;
        wts_t        wt;
        logic [11:0] waddr;
        logic [15:0] wdata;
    } st3_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        reject;
        wts_t        wt;
        logic [11:0] waddr;
        logic [15:0] wdata;
    } st4_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic                  reject;
        logic [2:0][3:0][22:0] prod;
        logic [8:0]            num;
        logic [8:0]            rem;
        logic [15:0]           tex0;
        logic [11:0]           waddr;
        logic [15:0]           wdata;
    } st5_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        reject;
        logic [15:0] blend;
        logic [8:0]  num;
        logic [8:0]  rem;
        logic [15:0] tex0;
        logic [11:0] waddr;
        logic [15:0] wdata;
    } st6_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        reject;
        logic [15:0] color;
        logic        use_pal;
        logic [7:0]  pidx;
        logic [11:0] waddr;
        logic [15:0] wdata;
    } st7_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        reject;
        logic [15:0] color;
        logic        use_pal;
    } st8_t;

    // Apply the address mode to one coordinate
    function automatic coord_t map_coord(logic signed [23:0] c, logic [1:0] mode);
        coord_t r;
        logic   neg;
        logic   over;
        neg      = c[23];
        over     = !neg && (c[22:COORD_BITS] != '0);
        r.reject = 1'b0;
        r.val    = c[COORD_BITS-1:0];
        case (mode)
            MODE_WRAP: r.val = c[COORD_BITS-1:0];
            MODE_ZERO:
            begin
                r.reject = neg || over;
                r.val    = c[COORD_BITS-1:0];
            end
            default:
            begin
                if (neg)
                    r.val = '0;
                else if (over)
                    r.val = '1;
            end
        endcase
        return r;
    endfunction

    // Three restoring remainder steps, most significant dividend bit first
    function automatic logic [8:0] mod_steps(logic [8:0] rem, logic [2:0] bits,
                                             logic [8:0] d);
        logic [9:0] r;
        logic [8:0] acc;
        acc = rem;
        for (int i = 2; i >= 0; i--)
        begin
            r = {acc, bits[i]};
            if (r >= {1'b0, d})
                r = r - {1'b0, d};
            acc = r[8:0];
        end
        return acc;
    endfunction

endpackage

/* sv/tsr_texel_banks.sv */
`timescale 1ns / 1ps

module tsr_texel_banks
    import tsr_pkg::*;
(
    input  logic        clk,
    input  logic        rd_en,
    input  taddr4_t     rd_addr,
    input  logic        wr_en,
    input  taddr_t      wr_addr,
    input  logic [15:0] wr_data,
    output texq_t       rd_data
);

    // Four identical copies: every write goes to all, each copy serves one tap
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [15:0] mem [TEXEL_DEPTH];

        always_ff @(posedge clk)
        begin
            if (wr_en)
                mem[wr_addr] <= wr_data;
            if (rd_en)
                rd_data[b] <= mem[rd_addr[b]];
        end
    end

endmodule

/* sv/texture_sampler_rgb565.sv */
`timescale 1ns / 1ps
// Throughput: one item per cycle in both filter modes while m_tready does
// not hold the result stream; four banked texel copies give the four
// bilinear taps from a single read.
// Reset: registers return to wrap mode, nearest, 64x64, palette off; the
// pipeline empties at once. Texel and palette memories are not cleared.

module texture_sampler_rgb565
    import tsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input item stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // u_coord, v_coord, write_addr, write_data, zero pad
    input  logic [1:0]  s_tuser,  // cmd
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // color
    output logic [0:0]  m_tuser   // out_of_range
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0] mode_reg;
    logic       bil_reg;
    logic [6:0] width_reg;
    logic [6:0] height_reg;
    logic       pal_en_reg;
    logic [8:0] pal_size_reg;
    logic [7:0] pal_ofs_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_WRAP;
            bil_reg      <= 1'b0;
            width_reg    <= 7'(MAX_DIM);
            height_reg   <= 7'(MAX_DIM);
            pal_en_reg   <= 1'b0;
            pal_size_reg <= '0;
            pal_ofs_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_ADDR_MODE: mode_reg     <= pwdata[1:0];
                REG_BILINEAR:  bil_reg      <= pwdata[0];
                REG_WIDTH:     width_reg    <= pwdata[6:0];
                REG_HEIGHT:    height_reg   <= pwdata[6:0];
                REG_PAL_EN:    pal_en_reg   <= pwdata[0];
                REG_PAL_SIZE:  pal_size_reg <= pwdata[8:0];
                REG_PAL_OFS:   pal_ofs_reg  <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_ADDR_MODE: prdata = {30'd0, mode_reg};
            REG_BILINEAR:  prdata = {31'd0, bil_reg};
            REG_WIDTH:     prdata = {25'd0, width_reg};
            REG_HEIGHT:    prdata = {25'd0, height_reg};
            REG_PAL_EN:    prdata = {31'd0, pal_en_reg};
            REG_PAL_SIZE:  prdata = {23'd0, pal_size_reg};
            REG_PAL_OFS:   prdata = {24'd0, pal_ofs_reg};
            default:       prdata = '0;
        endcase
    end

    // Effective dimensions: zero acts as one, anything past the max is capped
    logic [6:0] w_eff;
    logic [6:0] h_eff;

    always_comb
    begin
        w_eff = width_reg;
        h_eff = height_reg;
        if (width_reg == '0)
            w_eff = 7'd1;
        else if (width_reg > 7'(MAX_DIM))
            w_eff = 7'(MAX_DIM);
        if (height_reg == '0)
            h_eff = 7'd1;
        else if (height_reg > 7'(MAX_DIM))
            h_eff = 7'(MAX_DIM);
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage moves when the one after it can take
    // an item. Writes ride the same pipe and act at the memory stage, so
    // reads and writes stay in order with no forwarding.
    // ------------------------------------------------------------------
    logic [8:1] v_reg;
    logic [8:1] rdy;

    st1_t s1_reg, s1_next;
    st2_t s2_reg, s2_next;
    st3_t s3_reg, s3_next;
    st4_t s4_reg, s4_next;
    st5_t s5_reg, s5_next;
    st6_t s6_reg, s6_next;
    st7_t s7_reg, s7_next;
    st8_t s8_reg, s8_next;

    texq_t       tex_rd;
    logic [15:0] pal_rd_reg;

    always_comb
    begin
        // drop items that produce no result as soon as they reach the end
        rdy[8] = !v_reg[8] || (s8_reg.cmd != CMD_SAMPLE) || m_tready;
        for (int k = 7; k >= 1; k--)
            rdy[k] = !v_reg[k] || rdy[k+1];
    end

    assign s_tready = rdy[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (rdy[1])
                v_reg[1] <= s_tvalid;
            for (int k = 2; k <= 8; k++)
                if (rdy[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // Stage 1: capture the input item
    always_comb
    begin
        s1_next.cmd   = s_tuser;
        s1_next.u     = s_tdata[23:0];
        s1_next.v     = s_tdata[47:24];
        s1_next.waddr = s_tdata[59:48];
        s1_next.wdata = s_tdata[75:60];
    end

    // Stage 2: address mode, then scale to texel units
    coord_t     cu;
    coord_t     cv;
    logic [6:0] mu;
    logic [6:0] mv;

    always_comb
    begin
        cu = map_coord(s1_reg.u, mode_reg);
        cv = map_coord(s1_reg.v, mode_reg);
        // bilinear spans the texel centers 0..dim-1, nearest spans 0..dim
        mu = bil_reg ? w_eff - 7'd1 : w_eff;
        mv = bil_reg ? h_eff - 7'd1 : h_eff;
        s2_next.cmd    = s1_reg.cmd;
        s2_next.reject = cu.reject || cv.reject;
        s2_next.pu     = 15'(cu.val) * 15'(mu);
        s2_next.pv     = 15'(cv.val) * 15'(mv);
        s2_next.waddr  = s1_reg.waddr;
        s2_next.wdata  = s1_reg.wdata;
    end

    // Stage 3: neighbor texel addresses and blend weights
    logic [6:0]  x0, y0, x1, y1;
    logic [7:0]  ur, vr;
    logic [8:0]  uo, vo;
    logic [13:0] row0, row1;

    always_comb
    begin
        x0 = s2_reg.pu[14:8];
        y0 = s2_reg.pv[14:8];
        // hold the far neighbor on the last column or row
        x1 = ({1'b0, x0} + 8'd1 >= {1'b0, w_eff}) ? w_eff - 7'd1 : x0 + 7'd1;
        y1 = ({1'b0, y0} + 8'd1 >= {1'b0, h_eff}) ? h_eff - 7'd1 : y0 + 7'd1;
        ur = s2_reg.pu[7:0];
        vr = s2_reg.pv[7:0];
        uo = 9'(COORD_SCALE) - {1'b0, ur};
        vo = 9'(COORD_SCALE) - {1'b0, vr};
        row0 = 14'(y0) * 14'(w_eff);
        row1 = 14'(y1) * 14'(w_eff);
        s3_next.cmd     = s2_reg.cmd;
        s3_next.reject  = s2_reg.reject;
        s3_next.addr[0] = 12'(row0 + 14'(x0));
        s3_next.addr[1] = 12'(row0 + 14'(x1));
        s3_next.addr[2] = 12'(row1 + 14'(x0));
        s3_next.addr[3] = 12'(row1 + 14'(x1));
        s3_next.wt[0]   = 17'(uo) * 17'(vo);
        s3_next.wt[1]   = 17'(ur) * 17'(vo);
        s3_next.wt[2]   = 17'(uo) * 17'(vr);
        s3_next.wt[3]   = 17'(ur) * 17'(vr);
        s3_next.waddr   = s2_reg.waddr;
        s3_next.wdata   = s2_reg.wdata;
    end

    // Stage 4: texel memory read (four taps) or texel write
    tsr_texel_banks u_banks (
        .clk     (clk),
        .rd_en   (rdy[4]),
        .rd_addr (s3_reg.addr),
        .wr_en   (rdy[4] && v_reg[3] && (s3_reg.cmd == CMD_TEXEL)),
        .wr_addr (s3_reg.waddr),
        .wr_data (s3_reg.wdata),
        .rd_data (tex_rd)
    );

    always_comb
    begin
        s4_next.cmd    = s3_reg.cmd;
        s4_next.reject = s3_reg.reject;
        s4_next.wt     = s3_reg.wt;
        s4_next.waddr  = s3_reg.waddr;
        s4_next.wdata  = s3_reg.wdata;
    end

    // Stage 5: per-channel weighted products; start the palette remainder
    always_comb
    begin
        for (int t = 0; t < 4; t++)
        begin
            s5_next.prod[2][t] = 23'(tex_rd[t][15:11]) * 23'(s4_reg.wt[t]);
            s5_next.prod[1][t] = 23'(tex_rd[t][10:5]) * 23'(s4_reg.wt[t]);
            s5_next.prod[0][t] = 23'(tex_rd[t][4:0]) * 23'(s4_reg.wt[t]);
        end
        s5_next.cmd    = s4_reg.cmd;
        s5_next.reject = s4_reg.reject;
        s5_next.num    = {1'b0, tex_rd[0][7:0]} + {1'b0, pal_ofs_reg};
        s5_next.rem    = mod_steps(9'd0, s5_next.num[8:6], pal_size_reg);
        s5_next.tex0   = tex_rd[0];
        s5_next.waddr  = s4_reg.waddr;
        s5_next.wdata  = s4_reg.wdata;
    end

    // Stage 6: sum and scale down each channel; continue the palette remainder
    logic [2:0][22:0] csum;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            csum[c] = s5_reg.prod[c][0] + s5_reg.prod[c][1]
                    + s5_reg.prod[c][2] + s5_reg.prod[c][3];
        s6_next.cmd    = s5_reg.cmd;
        s6_next.reject = s5_reg.reject;
        s6_next.blend  = {csum[2][20:16], csum[1][21:16], csum[0][20:16]};
        s6_next.num    = s5_reg.num;
        s6_next.rem    = mod_steps(s5_reg.rem, s5_reg.num[5:3], pal_size_reg);
        s6_next.tex0   = s5_reg.tex0;
        s6_next.waddr  = s5_reg.waddr;
        s6_next.wdata  = s5_reg.wdata;
    end

    // Stage 7: finish the remainder and pick the palette index
    logic [8:0] rem_fin;

    always_comb
    begin
        rem_fin = mod_steps(s6_reg.rem, s6_reg.num[2:0], pal_size_reg);
        s7_next.cmd     = s6_reg.cmd;
        s7_next.reject  = s6_reg.reject;
        s7_next.color   = bil_reg ? s6_reg.blend : s6_reg.tex0;
        s7_next.use_pal = !bil_reg && pal_en_reg;
        s7_next.pidx    = (pal_size_reg != '0) ? rem_fin[7:0] : s6_reg.tex0[7:0];
        s7_next.waddr   = s6_reg.waddr;
        s7_next.wdata   = s6_reg.wdata;
    end

    // Stage 8: palette read or write; this stage is the output register
    logic [15:0] pal_mem [PALETTE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (rdy[8])
        begin
            if (v_reg[7] && (s7_reg.cmd == CMD_PALETTE) && (s7_reg.waddr[11:8] == '0))
                pal_mem[s7_reg.waddr[7:0]] <= s7_reg.wdata;
            pal_rd_reg <= pal_mem[s7_reg.pidx];
        end
    end

    always_comb
    begin
        s8_next.cmd     = s7_reg.cmd;
        s8_next.reject  = s7_reg.reject;
        s8_next.color   = s7_reg.color;
        s8_next.use_pal = s7_reg.use_pal;
    end

    // Payload registers: load whenever the stage advances
    always_ff @(posedge clk)
    begin
        if (rdy[1]) s1_reg <= s1_next;
        if (rdy[2]) s2_reg <= s2_next;
        if (rdy[3]) s3_reg <= s3_next;
        if (rdy[4]) s4_reg <= s4_next;
        if (rdy[5]) s5_reg <= s5_next;
        if (rdy[6]) s6_reg <= s6_next;
        if (rdy[7]) s7_reg <= s7_next;
        if (rdy[8]) s8_reg <= s8_next;
    end

    // Result: only samples produce an item; rejected ones read as zero
    assign m_tvalid   = v_reg[8] && (s8_reg.cmd == CMD_SAMPLE);
    assign m_tuser[0] = s8_reg.reject;
    assign m_tdata    = s8_reg.reject  ? 16'd0 :
                        s8_reg.use_pal ? pal_rd_reg : s8_reg.color;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 16'd0)
        else $error("rejected sample carries a nonzero color");

    a_reject_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (mode_reg != MODE_ZERO) |-> !m_tuser[0])
        else $error("out_of_range raised outside zero mode");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&v_reg) && m_tvalid && !m_tready)
        else $error("input stalled while the pipeline has room");

endmodule
